>>> rtl/bounded_stack_with_increment_core_macros.svh
// Assertion macros for the bounded stack with increment.
// Included by the RTL files that carry concurrent checks; clock clk, reset rst_n.
`ifndef BOUNDED_STACK_WITH_INCREMENT_CORE_MACROS_SVH
`define BOUNDED_STACK_WITH_INCREMENT_CORE_MACROS_SVH

// Same-cycle implication, held off while in reset.
`define BSI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off while in reset.
`define BSI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/bsi_pkg.sv
// Package for the bounded stack with increment: sizes, opcodes, word types.
// No dependencies; used by bsi_cell and bounded_stack_with_increment_core.
`timescale 1ns / 1ps

package bsi_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int IDX_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int COUNT_W     = $clog2(STACK_DEPTH + 1);
  localparam int DATA_W      = 32;
  localparam int CAP_W       = 11;
  localparam int FILL_W      = 11;
  localparam int CMP_W       = CAP_W + 1;

  localparam logic [CAP_W-1:0]  CAP_RESET = CAP_W'(64);
  localparam logic [DATA_W-1:0] EMPTY_POP = '1;   // -1 on pop of an empty stack

  typedef enum logic [1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_INC  = 2'd2,
    OP_NOP  = 2'd3
  } opcode_t;

  typedef struct packed {
    opcode_t            opcode;
    logic signed [31:0] operand_value;
    logic [10:0]        bottom_count;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] popped_value;
    logic               was_empty;
    logic               push_dropped;
    logic [10:0]        fill_level;
  } out_word_t;

  // Broadcast to every cell in the chain
  typedef struct packed {
    logic               push;
    logic               pop;
    logic               inc;
    logic [DATA_W-1:0]  operand;
    logic [CAP_W-1:0]   bottom_count;
    logic [COUNT_W-1:0] fill;
  } cell_ctrl_t;

endpackage

>>> rtl/bsi_cell.sv
// One stack cell: holds one entry, shifts with its neighbours, adds on increment.
// Depends on bsi_pkg.
`timescale 1ns / 1ps

module bsi_cell (
  input  logic                            clk,
  input  bsi_pkg::cell_ctrl_t             ctrl,
  input  logic [bsi_pkg::IDX_W-1:0]       idx,
  input  logic [bsi_pkg::DATA_W-1:0]      left_data,
  input  logic [bsi_pkg::DATA_W-1:0]      right_data,
  output logic [bsi_pkg::DATA_W-1:0]      data_out
);

  logic [bsi_pkg::DATA_W-1:0] data_r;
  logic [bsi_pkg::DATA_W-1:0] data_nxt;
  logic [bsi_pkg::CMP_W-1:0]  reach;
  logic                       held;
  logic                       sel;

  // Cell 0 is the top; entry position from the bottom is fill-1-idx.
  assign held  = bsi_pkg::CMP_W'(idx) < bsi_pkg::CMP_W'(ctrl.fill);
  assign reach = bsi_pkg::CMP_W'(idx) + bsi_pkg::CMP_W'(ctrl.bottom_count);
  assign sel   = held && (reach >= bsi_pkg::CMP_W'(ctrl.fill));

  always_comb begin
    data_nxt = data_r;
    if (ctrl.push) begin
      data_nxt = left_data;
    end else if (ctrl.pop) begin
      data_nxt = right_data;
    end else if (ctrl.inc && sel) begin
      data_nxt = data_r + ctrl.operand;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_out = data_r;

endmodule

>>> rtl/bounded_stack_with_increment_core.sv
// Bounded LIFO stack with bottom-increment, built as a shifting row of cells.
// Each operation is one cell update, its result registered in the next cycle.
// Throughput: one word per cycle while in_stall is low.
// Reset (rst_n, synchronous, active low): fill count 0, capacity 64, output empty.
// Depends on bsi_pkg, bsi_cell and bounded_stack_with_increment_core_macros.svh.
`timescale 1ns / 1ps
`include "bounded_stack_with_increment_core_macros.svh"

module bounded_stack_with_increment_core (
  input  logic                 clk,
  input  logic                 rst_n,
  // input channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  bsi_pkg::in_word_t    in_word,
  // result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output bsi_pkg::out_word_t   out_word,
  // capacity register
  input  logic                 cfg_we,
  input  logic [10:0]          cfg_wdata
);

  logic [bsi_pkg::CAP_W-1:0]   cap_r;
  logic [bsi_pkg::COUNT_W-1:0] count_r;
  logic [bsi_pkg::COUNT_W-1:0] count_nxt;
  logic [bsi_pkg::COUNT_W-1:0] count_inc;
  logic [bsi_pkg::COUNT_W-1:0] count_dec;
  logic                        out_valid_r;
  logic                        out_valid_nxt;
  bsi_pkg::out_word_t          out_word_r;
  bsi_pkg::out_word_t          out_word_nxt;

  logic                        accept;
  logic                        is_push;
  logic                        is_pop;
  logic                        is_inc;
  logic                        full;
  logic                        empty;
  bsi_pkg::cell_ctrl_t         ctrl;

  logic [bsi_pkg::DATA_W-1:0]  cell_q [bsi_pkg::STACK_DEPTH];

  // A new word may enter whenever the output register is free or being drained
  // in this same cycle, so the stack runs at one operation per clock.
  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  assign is_push = in_word.opcode == bsi_pkg::OP_PUSH;
  assign is_pop  = in_word.opcode == bsi_pkg::OP_POP;
  assign is_inc  = in_word.opcode == bsi_pkg::OP_INC;

  // Capacity is the smaller of the register and the physical depth; a
  // capacity lowered below the fill just blocks pushes.
  assign full  = (bsi_pkg::CAP_W'(count_r) >= cap_r) ||
                 (bsi_pkg::CMP_W'(count_r) >= bsi_pkg::CMP_W'(bsi_pkg::STACK_DEPTH));
  assign empty = count_r == '0;

  assign count_inc = count_r + 1'b1;
  assign count_dec = count_r - 1'b1;

  // Shift/add control broadcast down the chain
  always_comb begin
    ctrl.push         = accept && is_push && !full;
    ctrl.pop          = accept && is_pop && !empty;
    ctrl.inc          = accept && is_inc;
    ctrl.operand      = in_word.operand_value;
    ctrl.bottom_count = in_word.bottom_count;
    ctrl.fill         = count_r;
  end

  // Row of cells: cell 0 is the top of stack. Push shifts every entry one
  // cell deeper and loads the operand into cell 0; pop shifts toward the top.
  // The deepest cell feeds itself back on pop (its value is then unused).
  for (genvar i = 0; i < bsi_pkg::STACK_DEPTH; i++) begin : g_cell
    logic [bsi_pkg::DATA_W-1:0] left_d;
    logic [bsi_pkg::DATA_W-1:0] right_d;

    if (i == 0) begin : g_top
      assign left_d = in_word.operand_value;
    end else begin : g_mid
      assign left_d = cell_q[i-1];
    end

    if (i == bsi_pkg::STACK_DEPTH - 1) begin : g_last
      assign right_d = cell_q[i];
    end else begin : g_inner
      assign right_d = cell_q[i+1];
    end

    bsi_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .idx        (bsi_pkg::IDX_W'(i)),
      .left_data  (left_d),
      .right_data (right_d),
      .data_out   (cell_q[i])
    );
  end

  // Fill count and result word
  always_comb begin
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_word_nxt  = out_word_r;

    if (ctrl.push) begin
      count_nxt = count_inc;
    end else if (ctrl.pop) begin
      count_nxt = count_dec;
    end

    if (accept) begin
      out_valid_nxt             = 1'b1;
      out_word_nxt.popped_value = '0;
      out_word_nxt.was_empty    = 1'b0;
      out_word_nxt.push_dropped = 1'b0;
      if (is_pop) begin
        if (empty) begin
          out_word_nxt.popped_value = bsi_pkg::EMPTY_POP;
          out_word_nxt.was_empty    = 1'b1;
        end else begin
          out_word_nxt.popped_value = cell_q[0];
        end
      end else if (is_push && full) begin
        out_word_nxt.push_dropped = 1'b1;
      end
      out_word_nxt.fill_level = bsi_pkg::FILL_W'(count_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= bsi_pkg::CAP_RESET;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload register, no reset
  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // Checks
  `BSI_ASSERT_NOW(a_count_bound, 1'b1, 32'(count_r) <= 32'(bsi_pkg::STACK_DEPTH), "fill count beyond depth")
  `BSI_ASSERT_NOW(a_fill_match, out_valid_r, out_word_r.fill_level == bsi_pkg::FILL_W'(count_r), "reported fill differs from count")
  `BSI_ASSERT_NEXT(a_push_grows, ctrl.push, count_r == $past(count_inc), "accepted push did not grow the stack")
  `BSI_ASSERT_NEXT(a_pop_top, ctrl.pop, out_word_r.popped_value == $past(cell_q[0]), "pop did not return top cell")
  `BSI_ASSERT_NOW(a_no_dual_shift, 1'b1, !(ctrl.push && ctrl.pop), "push and pop shift together")

endmodule

>>> bench/tb_bounded_stack_with_increment_core.sv
// Self-checking bench for bounded_stack_with_increment_core: push, pop, increment, no-op.
// Predicts every result word from its own stack copy; needs bsi_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_bounded_stack_with_increment_core;
  import bsi_pkg::*;

  localparam int ITEMS_PER_PHASE = 200;
  localparam int N_PHASES        = 10;
  localparam int HOLD_CYCLES     = 300;     // long receiver hold-off to back the core up
  localparam int CYCLE_LIMIT     = 300000;

  // Stack predictor plus queue of result words still owed by the core
  class stack_scoreboard;
    logic [DATA_W-1:0] entries [STACK_DEPTH];
    int unsigned       fill;
    logic [CAP_W-1:0]  capacity;
    out_word_t         owed_words [$];
    int                errors;

    function new();
      fill     = 0;
      capacity = CAP_RESET;
      errors   = 0;
    endfunction

    function void set_capacity(logic [CAP_W-1:0] value);
      capacity = value;
    endfunction

    function int pending();
      return owed_words.size();
    endfunction

    // Apply one accepted input word to the model and queue the result it owes
    function void note_input(in_word_t w);
      out_word_t   e;
      int unsigned limit;
      int unsigned n;
      e = '0;
      limit = (capacity > STACK_DEPTH) ? STACK_DEPTH : capacity;
      case (w.opcode)
        OP_PUSH: begin
          if (fill < limit) begin
            entries[fill] = w.operand_value;
            fill++;
          end else begin
            e.push_dropped = 1'b1;
          end
        end
        OP_POP: begin
          if (fill == 0) begin
            e.popped_value = EMPTY_POP;
            e.was_empty    = 1'b1;
          end else begin
            fill--;
            e.popped_value = entries[fill];
          end
        end
        OP_INC: begin
          n = (w.bottom_count < fill) ? w.bottom_count : fill;
          for (int i = 0; i < n; i++) entries[i] = entries[i] + w.operand_value;
        end
        default: ;
      endcase
      e.fill_level = FILL_W'(fill);
      owed_words.insert(owed_words.size(), e);
    endfunction

    task report(string msg);
      $display("ERROR @%0t: %s", $time, msg);
      errors++;
    endtask

    task check_result(out_word_t got);
      out_word_t e;
      if (owed_words.size() == 0) begin
        report($sformatf("result word with none owed: %h", got));
      end else begin
        e = owed_words.pop_front();
        if (got.popped_value !== e.popped_value)
          report($sformatf("popped_value %h, want %h", got.popped_value, e.popped_value));
        if (got.was_empty !== e.was_empty)
          report($sformatf("was_empty %b, want %b", got.was_empty, e.was_empty));
        if (got.push_dropped !== e.push_dropped)
          report($sformatf("push_dropped %b, want %b", got.push_dropped, e.push_dropped));
        if (got.fill_level !== e.fill_level)
          report($sformatf("fill_level %0d, want %0d", got.fill_level, e.fill_level));
      end
    endtask
  endclass

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  logic             in_stall;
  in_word_t         in_word   = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  out_word_t        out_word;
  logic             cfg_we    = 1'b0;
  logic [CAP_W-1:0] cfg_wdata = '0;

  stack_scoreboard  sb;
  int               sender_idle_pct = 0;
  int               recv_stall_pct  = 0;
  logic             hold_armed      = 1'b0;
  logic             hold_off        = 1'b0;
  int unsigned      cycle_count     = 0;

  // Capacity per random phase: reset value, extremes, above-depth values, odd sizes
  logic [CAP_W-1:0] phase_cap [0:N_PHASES-1] =
    '{11'd64, 11'd1, 11'd2047, 11'd0, 11'd5, 11'd1024, 11'd65, 11'd63, 11'd16, 11'd64};

  bounded_stack_with_increment_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: counts every cycle and gives up well past the slowest honest run
  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count == CYCLE_LIMIT);
    $display("bounded_stack_with_increment_core: mismatch");
    $finish;
  end

  // Receiver: check each accepted result word, then pick next cycle's stall.
  // Everything here reads pre-edge values since the signals read here are driven nonblocking.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_word);
    out_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);
  end

  // Hold-off, counted here: once armed the receiver stalls for a long stretch
  // while the sender keeps offering, so the output register fills and in_stall rises.
  initial begin
    wait (hold_armed);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  function automatic in_word_t mk_word(opcode_t op, logic [31:0] value, logic [10:0] count);
    in_word_t w;
    w.opcode        = op;
    w.operand_value = value;
    w.bottom_count  = count;
    return w;
  endfunction

  // Random word; push_pct steers the fill level up (high) or down (low)
  function automatic in_word_t random_word(int push_pct);
    in_word_t w;
    int       r;
    r = $urandom_range(9);
    if ($urandom_range(99) < push_pct) w.opcode = OP_PUSH;
    else if (r < 6)                     w.opcode = OP_POP;
    else if (r < 9)                     w.opcode = OP_INC;
    else                                w.opcode = OP_NOP;
    case ($urandom_range(7))
      0:       w.operand_value = 32'h8000_0000;
      1:       w.operand_value = 32'h7fff_ffff;
      2:       w.operand_value = 32'hffff_ffff;
      3:       w.operand_value = $urandom_range(15);
      default: w.operand_value = $urandom;
    endcase
    case ($urandom_range(3))
      0:       w.bottom_count = 11'($urandom_range(3));
      1:       w.bottom_count = 11'($urandom_range(70));
      2:       w.bottom_count = 11'($urandom_range(2047));
      default: w.bottom_count = 11'($urandom_range(68, 60));
    endcase
    return w;
  endfunction

  // Offer one word, with random idle cycles first; return once it is taken
  task automatic send_word(in_word_t w);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall);
    sb.note_input(w);
  endtask

  // Stop sending and wait until every owed result word has come back
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (2) @(posedge clk);  // settling margin
  endtask

  // Capacity writes only happen with the core idle
  task automatic write_capacity(logic [CAP_W-1:0] value);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.set_capacity(value);
  endtask

  initial begin
    sb = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: tiny capacity so full, empty and wrap cases show up quickly
    write_capacity(11'd3);
    send_word(mk_word(OP_POP,  32'h0,         11'd0));     // pop on empty
    send_word(mk_word(OP_INC,  32'd5,         11'd4));     // increment on empty
    send_word(mk_word(OP_NOP,  32'hffff_ffff, 11'd2047));  // no-op: fill only
    send_word(mk_word(OP_PUSH, 32'h7fff_ffff, 11'd0));
    send_word(mk_word(OP_PUSH, 32'h8000_0000, 11'd2047));
    send_word(mk_word(OP_PUSH, 32'hffff_ffff, 11'd0));
    send_word(mk_word(OP_PUSH, 32'h0,         11'd0));     // full: dropped
    send_word(mk_word(OP_INC,  32'd1,         11'd2047));  // count past fill, wraps
    send_word(mk_word(OP_INC,  32'd123,       11'd0));     // zero count
    send_word(mk_word(OP_INC,  32'h8000_0000, 11'd1));     // bottom entry only

    // Capacity lowered under the fill level: entries kept, pushes dropped until pops bring the fill below it
    write_capacity(11'd1);
    send_word(mk_word(OP_PUSH, 32'h1111_1111, 11'd0));
    send_word(mk_word(OP_POP,  32'h0,         11'd0));
    send_word(mk_word(OP_INC,  32'hffff_ffff, 11'd5));
    send_word(mk_word(OP_POP,  32'h0,         11'd0));
    send_word(mk_word(OP_PUSH, 32'h0000_55aa, 11'd0));     // still at capacity
    send_word(mk_word(OP_POP,  32'h0,         11'd0));
    send_word(mk_word(OP_PUSH, 32'h0000_1234, 11'd0));
    send_word(mk_word(OP_POP,  32'h0,         11'd0));

    // Zero capacity: every push dropped
    write_capacity(11'd0);
    send_word(mk_word(OP_PUSH, 32'hdead_beef, 11'd0));
    send_word(mk_word(OP_POP,  32'h0,         11'd0));

    // Random phases: capacity, idling pattern and push bias change per phase
    for (int p = 0; p < N_PHASES; p++) begin
      int push_pct;
      write_capacity(phase_cap[p]);
      case (p % 4)
        0: begin sender_idle_pct = 0;  recv_stall_pct <= 0;  push_pct = 55; end
        1: begin sender_idle_pct = 52; recv_stall_pct <= 0;  push_pct = 65; end
        2: begin sender_idle_pct = 0;  recv_stall_pct <= 52; push_pct = 35; end
        default: begin sender_idle_pct = 30; recv_stall_pct <= 30; push_pct = 45; end
      endcase
      if (p == 2) hold_armed <= 1'b1;
      repeat (ITEMS_PER_PHASE) send_word(random_word(push_pct));
    end

    drain();
    repeat (4) @(posedge clk);
    if (sb.errors == 0) $display("bounded_stack_with_increment_core: match");
    else                $display("bounded_stack_with_increment_core: mismatch");
    $finish;
  end

endmodule
